/* sv/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and arithmetic helpers for the pressure and
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 48;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_COEFFS = 2'd0,
      CSR_PRES_LOW    = 2'd1,
      CSR_PRES_MID    = 2'd2,
      CSR_PRES_HIGH   = 2'd3
   } csr_index_type;

   typedef logic [31:0] word_type;

   localparam word_type PRES_OFFSET  = 32'd64000;
   localparam word_type PRES_FULL    = 32'd1048576;
   localparam word_type PRES_SCALE   = 32'd3125;
   localparam word_type DIG1_BIAS    = 32'd32768;
   localparam word_type TEMP_ROUND   = 32'd128;

   // arithmetic shift right of a 32-bit two's complement word
   function automatic word_type asr(input word_type v, input logic [4:0] s);
      return word_type'($signed(v) >>> s);
   endfunction

   // sign-extend a 16-bit calibration word
   function automatic word_type sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

/* sv/pressure_temperature_compensation.sv */
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Pipelined 32-bit integer compensation of raw barometric readings.
// ----------------------------------------------------------------------------
// One reading (raw pressure and raw temperature) is accepted per cycle and
// one result leaves per cycle while no result is stalled. The pipe has 23
// register stages, the first one loaded at the input transfer edge. The
// depth is set by the 32-bit unsigned pressure divide, which takes one load
// stage and then eight pipeline stages resolving four quotient bits each,
// plus eleven stages of multiply/shift arithmetic before it and three after
// it. A stall on rsp_ while a result is held freezes the whole pipe, so
// req_stall rises in the same cycle. Calibration words are written
// through the csr_ port (always ready) and must only change while the pipe is
// empty. When the pressure divisor comes out zero the pressure is forced to 0
// and rsp_divisor_zero is set; the temperature is still reported.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
   input  logic                               clock,
   input  logic                               reset,
   // input readings
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [19:0]                        req_raw_pressure,
   input  logic [19:0]                        req_raw_temperature,
   // results
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [31:0]                 rsp_temperature_centi,
   output logic [31:0]                        rsp_pressure_pa,
   output logic                               rsp_divisor_zero,
   // calibration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptc_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   localparam int NUM_STG  = 23;
   localparam int DIV_STG  = 8;
   localparam int DIV_BITS = 4;

   // ---------------------------------------------------------------------
   // Calibration registers
   // ---------------------------------------------------------------------
   logic [ptc_pkg::CSR_DAT_W-1:0] temp_coeffs_ff, pres_low_ff, pres_mid_ff, pres_high_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         pres_low_ff    <= '0;
         pres_mid_ff    <= '0;
         pres_high_ff   <= '0;
      end else if (csr_valid) begin
         case (ptc_pkg::csr_index_type'(csr_index))
            ptc_pkg::CSR_TEMP_COEFFS: temp_coeffs_ff <= csr_wdata;
            ptc_pkg::CSR_PRES_LOW:    pres_low_ff    <= csr_wdata;
            ptc_pkg::CSR_PRES_MID:    pres_mid_ff    <= csr_wdata;
            ptc_pkg::CSR_PRES_HIGH:   pres_high_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Unpack the twelve words; first and fourth are unsigned.
   ptc_pkg::word_type t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {16'b0, temp_coeffs_ff[15:0]};
   assign t2 = ptc_pkg::sx16(temp_coeffs_ff[31:16]);
   assign t3 = ptc_pkg::sx16(temp_coeffs_ff[47:32]);
   assign p1 = {16'b0, pres_low_ff[15:0]};
   assign p2 = ptc_pkg::sx16(pres_low_ff[31:16]);
   assign p3 = ptc_pkg::sx16(pres_low_ff[47:32]);
   assign p4 = ptc_pkg::sx16(pres_mid_ff[15:0]);
   assign p5 = ptc_pkg::sx16(pres_mid_ff[31:16]);
   assign p6 = ptc_pkg::sx16(pres_mid_ff[47:32]);
   assign p7 = ptc_pkg::sx16(pres_high_ff[15:0]);
   assign p8 = ptc_pkg::sx16(pres_high_ff[31:16]);
   assign p9 = ptc_pkg::sx16(pres_high_ff[47:32]);

   // ---------------------------------------------------------------------
   // Flow control: every stage advances together unless the result
   // register holds a transfer the consumer is stalling.
   // ---------------------------------------------------------------------
   logic [NUM_STG-1:0] vld_ff;
   logic               adv;

   assign adv       = !(vld_ff[NUM_STG-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NUM_STG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STG-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------------
   // Temperature path and pressure pre-scaling (stages 1..11)
   // ---------------------------------------------------------------------
   ptc_pkg::word_type s1_x_ff, s1_d_ff;
   ptc_pkg::word_type s2_m1_ff, s2_dd_ff;
   ptc_pkg::word_type s3_at_ff, s3_e_ff;
   ptc_pkg::word_type s4_fine_ff;
   ptc_pkg::word_type s5_temp_ff, s5_pa_ff;
   ptc_pkg::word_type s6_qq_ff, s6_m5_ff, s6_m2_ff, s6_temp_ff;
   ptc_pkg::word_type s7_b1_ff, s7_m3_ff, s7_m5_ff, s7_m2_ff, s7_temp_ff;
   ptc_pkg::word_type s8_b_ff, s8_a2_ff, s8_temp_ff;
   ptc_pkg::word_type s9_m_ff, s9_b_ff, s9_temp_ff;
   ptc_pkg::word_type s10_av_ff, s10_n_ff, s10_temp_ff;
   ptc_pkg::word_type s11_pr_ff, s11_av_ff, s11_temp_ff;
   logic [19:0]       rp_ff [1:9];

   ptc_pkg::word_type rt_w, s5_q, s6_q;
   assign rt_w = {12'b0, req_raw_temperature};
   assign s6_q = ptc_pkg::asr(s5_pa_ff, 5'd2);
   assign s5_q = (s4_fine_ff << 2) + s4_fine_ff;   // fine * 5

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1: offsets of raw temperature
         s1_x_ff  <= (rt_w >> 3) - (t1 << 1);
         s1_d_ff  <= (rt_w >> 4) - t1;
         rp_ff[1] <= req_raw_pressure;
         // stage 2: first products
         s2_m1_ff <= s1_x_ff * t2;
         s2_dd_ff <= s1_d_ff * s1_d_ff;
         rp_ff[2] <= rp_ff[1];
         // stage 3
         s3_at_ff <= ptc_pkg::asr(s2_m1_ff, 5'd11);
         s3_e_ff  <= ptc_pkg::asr(s2_dd_ff, 5'd12) * t3;
         rp_ff[3] <= rp_ff[2];
         // stage 4: fine temperature
         s4_fine_ff <= s3_at_ff + ptc_pkg::asr(s3_e_ff, 5'd14);
         rp_ff[4]   <= rp_ff[3];
         // stage 5: temperature out, pressure offset in
         s5_temp_ff <= ptc_pkg::asr(s5_q + ptc_pkg::TEMP_ROUND, 5'd8);
         s5_pa_ff   <= ptc_pkg::asr(s4_fine_ff, 5'd1) - ptc_pkg::PRES_OFFSET;
         rp_ff[5]   <= rp_ff[4];
         // stage 6
         s6_qq_ff   <= s6_q * s6_q;
         s6_m5_ff   <= s5_pa_ff * p5;
         s6_m2_ff   <= p2 * s5_pa_ff;
         s6_temp_ff <= s5_temp_ff;
         rp_ff[6]   <= rp_ff[5];
         // stage 7
         s7_b1_ff   <= ptc_pkg::asr(s6_qq_ff, 5'd11) * p6;
         s7_m3_ff   <= p3 * ptc_pkg::asr(s6_qq_ff, 5'd13);
         s7_m5_ff   <= s6_m5_ff;
         s7_m2_ff   <= s6_m2_ff;
         s7_temp_ff <= s6_temp_ff;
         rp_ff[7]   <= rp_ff[6];
         // stage 8: sum the partial terms
         s8_b_ff    <= ptc_pkg::asr(s7_b1_ff + (s7_m5_ff << 1), 5'd2) + (p4 << 16);
         s8_a2_ff   <= ptc_pkg::asr(ptc_pkg::asr(s7_m3_ff, 5'd3)
                                    + ptc_pkg::asr(s7_m2_ff, 5'd1), 5'd18);
         s8_temp_ff <= s7_temp_ff;
         rp_ff[8]   <= rp_ff[7];
         // stage 9: divisor product
         s9_m_ff    <= (ptc_pkg::DIG1_BIAS + s8_a2_ff) * p1;
         s9_b_ff    <= s8_b_ff;
         s9_temp_ff <= s8_temp_ff;
         rp_ff[9]   <= rp_ff[8];
         // stage 10: divisor and numerator base
         s10_av_ff   <= ptc_pkg::asr(s9_m_ff, 5'd15);
         s10_n_ff    <= ptc_pkg::PRES_FULL - {12'b0, rp_ff[9]}
                        - ptc_pkg::asr(s9_b_ff, 5'd12);
         s10_temp_ff <= s9_temp_ff;
         // stage 11: scale numerator
         s11_pr_ff   <= s10_n_ff * ptc_pkg::PRES_SCALE;
         s11_av_ff   <= s10_av_ff;
         s11_temp_ff <= s10_temp_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Unsigned divide, four quotient bits per stage. Index 0 is the load
   // stage; work holds untouched dividend bits and shifts quotient bits in.
   // ---------------------------------------------------------------------
   ptc_pkg::word_type div_work_ff [0:DIV_STG];
   ptc_pkg::word_type div_d_ff    [0:DIV_STG];
   ptc_pkg::word_type div_temp_ff [0:DIV_STG];
   ptc_pkg::word_type div_rem_ff  [1:DIV_STG];
   logic              div_top_ff  [0:DIV_STG];
   logic              div_zero_ff [0:DIV_STG];

   ptc_pkg::word_type div_work_in [1:DIV_STG];
   ptc_pkg::word_type div_rem_in  [1:DIV_STG];

   always_comb begin
      logic [32:0]       rem33;
      ptc_pkg::word_type rem, work;
      logic              ge;
      for (int k = 1; k <= DIV_STG; k++) begin
         rem  = (k == 1) ? '0 : div_rem_ff[(k == 1) ? 1 : k-1];
         work = div_work_ff[k-1];
         for (int b = 0; b < DIV_BITS; b++) begin
            rem33 = {rem, work[31]};
            ge    = (rem33 >= {1'b0, div_d_ff[k-1]});
            rem   = ge ? 32'(rem33 - {1'b0, div_d_ff[k-1]}) : rem33[31:0];
            work  = {work[30:0], ge};
         end
         div_rem_in[k]  = rem;
         div_work_in[k] = work;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // load: halve the range when the numerator top bit is set
         div_work_ff[0] <= s11_pr_ff[31] ? s11_pr_ff : (s11_pr_ff << 1);
         div_d_ff[0]    <= s11_av_ff;
         div_top_ff[0]  <= s11_pr_ff[31];
         div_zero_ff[0] <= (s11_av_ff == '0);
         div_temp_ff[0] <= s11_temp_ff;
         for (int k = 1; k <= DIV_STG; k++) begin
            div_work_ff[k] <= div_work_in[k];
            div_rem_ff[k]  <= div_rem_in[k];
            div_d_ff[k]    <= div_d_ff[k-1];
            div_top_ff[k]  <= div_top_ff[k-1];
            div_zero_ff[k] <= div_zero_ff[k-1];
            div_temp_ff[k] <= div_temp_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Final pressure correction and result register
   // ---------------------------------------------------------------------
   ptc_pkg::word_type pp_pres, pp_qv;
   ptc_pkg::word_type p1_pres_ff, p1_qq_ff, p1_m8_ff, p1_temp_ff;
   ptc_pkg::word_type p2_pres_ff, p2_a9_ff, p2_b8_ff, p2_temp_ff;
   logic              p1_zero_ff, p2_zero_ff;
   ptc_pkg::word_type pres_out_ff, temp_out_ff;
   logic              zero_out_ff;

   assign pp_pres = div_top_ff[DIV_STG] ? (div_work_ff[DIV_STG] << 1) : div_work_ff[DIV_STG];
   assign pp_qv   = pp_pres >> 3;

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_pres_ff <= pp_pres;
         p1_qq_ff   <= pp_qv * pp_qv;
         p1_m8_ff   <= (pp_pres >> 2) * p8;
         p1_zero_ff <= div_zero_ff[DIV_STG];
         p1_temp_ff <= div_temp_ff[DIV_STG];

         p2_a9_ff   <= ptc_pkg::asr(p9 * (p1_qq_ff >> 13), 5'd12);
         p2_b8_ff   <= ptc_pkg::asr(p1_m8_ff, 5'd13);
         p2_pres_ff <= p1_pres_ff;
         p2_zero_ff <= p1_zero_ff;
         p2_temp_ff <= p1_temp_ff;

         // force zero pressure when the divisor vanished
         pres_out_ff <= p2_zero_ff ? '0
                        : p2_pres_ff + ptc_pkg::asr(p2_a9_ff + p2_b8_ff + p7, 5'd4);
         zero_out_ff <= p2_zero_ff;
         temp_out_ff <= p2_temp_ff;
      end
   end

   assign rsp_temperature_centi = temp_out_ff;
   assign rsp_pressure_pa       = pres_out_ff;
   assign rsp_divisor_zero      = zero_out_ff;

endmodule

/* sv/ptc_checker.sv */
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks for the compensation pipeline.
// ----------------------------------------------------------------------------
module ptc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [31:0]                   rsp_temperature_centi,
   input logic [31:0]                   rsp_pressure_pa,
   input logic                          rsp_divisor_zero
);

   // pipe empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pressure_pa)
         && $stable(rsp_temperature_centi) && $stable(rsp_divisor_zero))
      else $error("stalled result changed");

   // zero divisor forces zero pressure
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divisor_zero |-> rsp_pressure_pa == '0)
      else $error("pressure not zero on zero divisor");

   // backpressure propagates only from a blocked result
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall mismatch");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_temperature_centi (rsp_temperature_centi),
   .rsp_pressure_pa       (rsp_pressure_pa),
   .rsp_divisor_zero      (rsp_divisor_zero)
);

/* sim/ptc_checker.sv */
// ----------------------------------------------------------------------------
// ptc_scoreboard
// Watches the reading, result and calibration channels of the compensation
// pipeline, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module ptc_scoreboard (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [19:0]            req_raw_pressure,
   input  logic [19:0]            req_raw_temperature,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [31:0]            rsp_temperature_centi,
   input  logic [31:0]            rsp_pressure_pa,
   input  logic                   rsp_divisor_zero,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  ptc_pkg::csr_index_type csr_index,
   input  logic [47:0]            csr_wdata,
   output int                     fail_count,
   output int                     pending_count
);

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] pres;
      logic        dz;
   } reading_result_type;

   logic [47:0] cal_temp, cal_plo, cal_pmid, cal_phi;
   reading_result_type compensated_q[$];

   function automatic logic [31:0] sra(input logic [31:0] v, input int s);
      return $signed(v) >>> s;
   endfunction

   function automatic logic [31:0] sw(input logic [47:0] r, input int n);
      logic [15:0] w;
      w = r[16*n +: 16];
      return {{16{w[15]}}, w};
   endfunction

   function automatic reading_result_type compensate(input logic [19:0] rp,
                                                     input logic [19:0] rt);
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] a, b, d, fine, q, qq, pres;
      reading_result_type r;
      t1 = {16'd0, cal_temp[15:0]};
      t2 = sw(cal_temp, 1);
      t3 = sw(cal_temp, 2);
      p1 = {16'd0, cal_plo[15:0]};
      p2 = sw(cal_plo, 1);
      p3 = sw(cal_plo, 2);
      p4 = sw(cal_pmid, 0);
      p5 = sw(cal_pmid, 1);
      p6 = sw(cal_pmid, 2);
      p7 = sw(cal_phi, 0);
      p8 = sw(cal_phi, 1);
      p9 = sw(cal_phi, 2);
      a = sra(((32'(rt) >> 3) - (t1 << 1)) * t2, 11);
      d = (32'(rt) >> 4) - t1;
      b = sra(sra(d * d, 12) * t3, 14);
      fine = a + b;
      r.temp = sra(fine * 32'd5 + 32'd128, 8);
      a = sra(fine, 1) - 32'd64000;
      q = sra(a, 2);
      qq = q * q;
      b = sra(qq, 11) * p6;
      b = b + ((a * p5) << 1);
      b = sra(b, 2) + (p4 << 16);
      a = sra(sra(p3 * sra(qq, 13), 3) + sra(p2 * a, 1), 18);
      a = sra((32'd32768 + a) * p1, 15);
      if (a == 0) begin
         r.pres = '0;
         r.dz = 1'b1;
      end else begin
         r.dz = 1'b0;
         pres = ((32'd1048576 - 32'(rp)) - sra(b, 12)) * 32'd3125;
         if (pres < 32'h8000_0000) pres = (pres << 1) / a;
         else pres = (pres / a) * 32'd2;
         q = pres >> 3;
         a = sra(p9 * ((q * q) >> 13), 12);
         b = sra((pres >> 2) * p8, 13);
         r.pres = pres + sra(a + b + p7, 4);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reading_result_type e;
      int errs;
      errs = 0;
      if (reset) begin
         cal_temp <= '0; cal_plo <= '0; cal_pmid <= '0; cal_phi <= '0;
         fail_count <= 0;
         compensated_q.delete();
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            compensated_q.push_back(compensate(req_raw_pressure, req_raw_temperature));
         if (rsp_valid && !rsp_stall) begin
            if (compensated_q.size() == 0) begin
               $error("unexpected result transfer");
               errs++;
            end else begin
               e = compensated_q.pop_front();
               if (rsp_temperature_centi !== e.temp) begin
                  $error("temperature_centi exp %0d got %0d", $signed(e.temp),
                         $signed(rsp_temperature_centi));
                  errs++;
               end
               if (rsp_pressure_pa !== e.pres) begin
                  $error("pressure_pa exp %0d got %0d", e.pres, rsp_pressure_pa);
                  errs++;
               end
               if (rsp_divisor_zero !== e.dz) begin
                  $error("divisor_zero exp %0d got %0d", e.dz, rsp_divisor_zero);
                  errs++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ptc_pkg::CSR_TEMP_COEFFS: cal_temp <= csr_wdata;
               ptc_pkg::CSR_PRES_LOW:    cal_plo  <= csr_wdata;
               ptc_pkg::CSR_PRES_MID:    cal_pmid <= csr_wdata;
               ptc_pkg::CSR_PRES_HIGH:   cal_phi  <= csr_wdata;
               default: ;
            endcase
         end
         fail_count <= fail_count + errs;
         pending_count <= compensated_q.size();
      end
   end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives raw readings and calibration sets into the compensation pipeline
// under random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, rsp_divisor_zero;
   logic [19:0] req_raw_pressure, req_raw_temperature;
   logic signed [31:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_pa;
   logic csr_valid, csr_ready;
   ptc_pkg::csr_index_type csr_index;
   logic [47:0] csr_wdata;
   int fail_count, pending_count;
   int send_idle_pct, recv_idle_pct;
   int cycle_count;

   pressure_temperature_compensation dut (.*);

   ptc_scoreboard chk (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Abort on a hung pipe.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 200000) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   // Receiver: stall at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Write one calibration register; the port is always ready but honor it anyway.
   task automatic write_cal(input ptc_pkg::csr_index_type idx, input logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Hold a reading until the transfer happens; idle randomly beforehand.
   task automatic send_reading(input logic [19:0] rp, input logic [19:0] rt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_pressure <= rp;
      req_raw_temperature <= rt;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait for the pipe to drain before touching calibration.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Realistic calibration set with random spread around typical values.
   task automatic load_typical;
      write_cal(ptc_pkg::CSR_TEMP_COEFFS, {16'($urandom_range(0, 200) - 100),
                                           16'($urandom_range(25000, 27000)),
                                           16'($urandom_range(27000, 28500))});
      write_cal(ptc_pkg::CSR_PRES_LOW, {16'($urandom_range(5000, 7000)),
                                        16'(-$urandom_range(10000, 11000)),
                                        16'($urandom_range(35000, 38000))});
      write_cal(ptc_pkg::CSR_PRES_MID, {16'(-$urandom_range(6, 8)),
                                        16'($urandom_range(0, 200)),
                                        16'($urandom_range(2000, 9000))});
      write_cal(ptc_pkg::CSR_PRES_HIGH, {16'(-$urandom_range(5000, 12000)),
                                         16'(-$urandom_range(7000, 15000)),
                                         16'($urandom_range(0, 30))});
   endtask

   task automatic load_random;
      write_cal(ptc_pkg::CSR_TEMP_COEFFS, 48'({$urandom, $urandom}));
      write_cal(ptc_pkg::CSR_PRES_LOW, 48'({$urandom, $urandom}));
      write_cal(ptc_pkg::CSR_PRES_MID, 48'({$urandom, $urandom}));
      write_cal(ptc_pkg::CSR_PRES_HIGH, 48'({$urandom, $urandom}));
   endtask

   task automatic load_all(input logic [47:0] v);
      write_cal(ptc_pkg::CSR_TEMP_COEFFS, v);
      write_cal(ptc_pkg::CSR_PRES_LOW, v);
      write_cal(ptc_pkg::CSR_PRES_MID, v);
      write_cal(ptc_pkg::CSR_PRES_HIGH, v);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_pressure = '0;
      req_raw_temperature = '0;
      csr_valid = 1'b0;
      csr_index = ptc_pkg::CSR_TEMP_COEFFS;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset calibration: P1 is zero, so every reading hits the zero divisor.
      send_reading(20'h0, 20'h0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      drain();

      // Extremes of calibration: all ones, then all zeros except sign bits.
      load_all(48'hFFFF_FFFF_FFFF);
      send_reading(20'h0, 20'hFFFFF);
      send_reading(20'hFFFFF, 20'h0);
      send_reading(20'h55555, 20'hAAAAA);
      drain();
      load_all(48'h8000_8000_8000);
      send_reading(20'hAAAAA, 20'h55555);
      send_reading(20'h80000, 20'h7FFFF);
      drain();

      // Typical sets: readings spanning the full field range, including the
      // large quotient path where the scaled numerator has its top bit set.
      load_typical();
      send_reading(20'h0, 20'h0);
      send_reading(20'hFFFFF, 20'hFFFFF);
      send_reading(20'd415148, 20'd519888);
      send_reading(20'd100, 20'd519888);
      send_reading(20'd1, 20'd300000);
      send_reading(20'd700000, 20'd700000);
      drain();

      // Random part in three idling phases with fresh calibration between chunks.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 49 : 0;
         recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 26 : 0;
         for (int chunk = 0; chunk < 5; chunk++) begin
            if (chunk == 4) load_random();
            else load_typical();
            for (int i = 0; i < 30; i++) begin
               if ($urandom_range(9) == 0)
                  send_reading(20'($urandom), 20'($urandom));
               else
                  send_reading(20'($urandom_range(200000, 600000)),
                               20'($urandom_range(400000, 600000)));
            end
            drain();
         end
      end

      if (fail_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule
